// ----- hw/rtl/lcd4_pkg.sv -----
package lcd4_pkg;

    localparam int WAIT_W = 14;

    localparam logic [WAIT_W-1:0] T_POWERUP     = WAIT_W'(15000);
    localparam logic [WAIT_W-1:0] T_INIT_GAP    = WAIT_W'(5000);
    localparam logic [WAIT_W-1:0] T_NIBBLE_HOLD = WAIT_W'(100);
    localparam logic [WAIT_W-1:0] T_SHORT       = WAIT_W'(40);
    localparam logic [WAIT_W-1:0] T_LONG        = WAIT_W'(2000);

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_COMMAND = 2'd1;
    localparam logic [1:0] CMD_DATA    = 2'd2;
    localparam logic [1:0] CMD_POWERUP = 2'd3;

    localparam logic [7:0] CLR_BYTE  = 8'h01;
    localparam logic [7:0] HOME_BYTE = 8'h02;

    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;

    localparam logic [3:0] STEP_NONE      = 4'd0;
    localparam logic [3:0] STEP_FIRST     = 4'd1;
    localparam logic [3:0] STEP_LAST_WAKE = 4'd3;
    localparam logic [3:0] STEP_NIB_LAST  = 4'd4;
    localparam logic [3:0] STEP_CMD_FIRST = 4'd5;
    localparam logic [3:0] STEP_CMD_NEXT  = 4'd8;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PWRWAIT  = 3'd1,
        PH_STROBE   = 3'd2,
        PH_HOLD     = 3'd3,
        PH_POSTWAIT = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
    } req_t;

    typedef struct packed {
        logic       register_select;
        logic       enable;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       rejected;
    } res_t;

    typedef struct packed {
        phase_t            phase;
        logic [WAIT_W-1:0] wait_left;
        logic [7:0]        pending_byte;
        logic              pending_select;
        logic [3:0]        init_step;
        logic              second_half;
        logic [3:0]        bus_nibble;
    } st_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h08;
            3'd2:    c = 8'h01;
            3'd3:    c = 8'h06;
            default: c = 8'h0C;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/lcd4_step.sv -----
module lcd4_step (
    input  lcd4_pkg::st_t  cur,
    input  lcd4_pkg::req_t req,
    output lcd4_pkg::st_t  nxt,
    output lcd4_pkg::res_t res
);
    import lcd4_pkg::*;

    always_comb
    begin
        st_t               s;
        logic              en;
        logic              rej;
        logic              longw;
        logic [WAIT_W-1:0] w;
        logic [3:0]        idx4;

        s     = cur;
        en    = 1'b0;
        rej   = 1'b0;
        longw = 1'b0;
        w     = '0;
        idx4  = '0;

        if (req.cmd != CMD_NONE)
        begin
            if (cur.phase != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else if (req.cmd == CMD_POWERUP)
            begin
                s.init_step      = STEP_FIRST;
                s.pending_select = 1'b0;
                s.second_half    = 1'b0;
                s.wait_left      = T_POWERUP;
                s.phase          = PH_PWRWAIT;
            end
            else
            begin
                s.init_step      = STEP_NONE;
                s.pending_byte   = req.value;
                s.pending_select = (req.cmd == CMD_DATA);
                s.second_half    = 1'b0;
                s.phase          = PH_STROBE;
            end
        end

        case (s.phase)
            PH_STROBE:
            begin
                if (s.init_step >= STEP_FIRST && s.init_step <= STEP_NIB_LAST)
                    s.bus_nibble = (s.init_step == STEP_NIB_LAST) ? NIB_4BIT : NIB_WAKE;
                else if (s.second_half)
                    s.bus_nibble = s.pending_byte[3:0];
                else
                    s.bus_nibble = s.pending_byte[7:4];
                en          = 1'b1;
                s.phase     = PH_HOLD;
                s.wait_left = T_NIBBLE_HOLD;
            end
            PH_HOLD, PH_POSTWAIT, PH_PWRWAIT:
            begin
                w = (s.wait_left != '0) ? s.wait_left - WAIT_W'(1) : '0;
                s.wait_left = w;
                if (w == '0)
                begin
                    if (s.phase == PH_HOLD)
                    begin
                        if (s.init_step >= STEP_FIRST && s.init_step <= STEP_NIB_LAST)
                        begin
                            s.phase     = PH_POSTWAIT;
                            s.wait_left = T_INIT_GAP;
                        end
                        else if (!s.second_half)
                        begin
                            s.second_half = 1'b1;
                            s.phase       = PH_STROBE;
                        end
                        else
                        begin
                            longw = !s.pending_select &&
                                    (s.pending_byte == CLR_BYTE || s.pending_byte == HOME_BYTE);
                            s.phase     = PH_POSTWAIT;
                            s.wait_left = longw ? T_LONG : T_SHORT;
                        end
                    end
                    else if (s.phase == PH_POSTWAIT)
                    begin
                        if (s.init_step >= STEP_FIRST && s.init_step <= STEP_LAST_WAKE)
                        begin
                            s.init_step = s.init_step + 4'd1;
                            s.phase     = PH_STROBE;
                        end
                        else if (s.init_step >= STEP_NIB_LAST && s.init_step <= STEP_CMD_NEXT)
                        begin
                            s.init_step      = s.init_step + 4'd1;
                            idx4             = s.init_step - STEP_CMD_FIRST;
                            s.pending_byte   = init_cmd((idx4 > 4'd4) ? 3'd4 : idx4[2:0]);
                            s.pending_select = 1'b0;
                            s.second_half    = 1'b0;
                            s.phase          = PH_STROBE;
                        end
                        else
                        begin
                            s.init_step = STEP_NONE;
                            s.phase     = PH_IDLE;
                        end
                    end
                    else
                    begin
                        s.phase = PH_STROBE;
                    end
                end
            end
            default:
            begin
                s.phase = PH_IDLE;
            end
        endcase

        nxt                 = s;
        res.register_select = s.pending_select;
        res.enable          = en;
        res.data_nibble     = s.bus_nibble;
        res.busy_res        = (s.phase != PH_IDLE);
        res.rejected        = rej;
    end

endmodule

// ----- hw/rtl/char_lcd_4bit_write_sequencer.sv -----
// channel | signals                      | payload
// --------+------------------------------+--------------------------------------------
// request | req_valid, req_ready, req    | cmd, value
// result  | res_valid, res_ready, res    | register_select, enable, data_nibble,
//         |                              | busy_res, rejected
//
// One request per clock while req_ready is high; its result is registered and appears the next cycle.
// The state update and result come from one combinational pass over the state registers.
// req_ready is high whenever the result register is empty or being taken this cycle.
// A stalled result holds req_ready low; the sequencer state only advances on an accepted request.
// rst_n (async, active low) clears the sequencer to idle and empties the result register.
module char_lcd_4bit_write_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lcd4_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_ready,
    output lcd4_pkg::res_t res
);
    import lcd4_pkg::*;

    st_t  st_reg;
    st_t  st_next;
    res_t res_reg;
    res_t res_next;
    logic res_valid_reg;
    logic accept;

    assign req_ready = !res_valid_reg || res_ready;
    assign accept    = req_valid && req_ready;

    lcd4_step u_step (
        .cur (st_reg),
        .req (req),
        .nxt (st_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase          <= PH_IDLE;
            st_reg.wait_left      <= '0;
            st_reg.pending_byte   <= '0;
            st_reg.pending_select <= 1'b0;
            st_reg.init_step      <= '0;
            st_reg.second_half    <= 1'b0;
            st_reg.bus_nibble     <= '0;
            res_valid_reg         <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_reg <= st_next;
            end
            if (accept)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.enable |-> res_reg.busy_res)
        else $error("enable strobe reported while idle");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.cmd != CMD_NONE && st_reg.phase != PH_IDLE |=> res_reg.rejected)
        else $error("request while busy not rejected");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(st_reg))
        else $error("state moved without an accepted request");

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase == PH_IDLE |-> st_reg.init_step == STEP_NONE)
        else $error("power-up step left over in idle");

    a_wait_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.wait_left <= T_POWERUP)
        else $error("wait counter out of range");

endmodule
